### hdl/tbd_pkg.sv
// shared types and constants for the token bucket delay block
package tbd_pkg;

    // fixed scaling of the bucket
    localparam int unsigned TICKS_PER_SECOND = 1000;
    localparam int unsigned MILLI_PER_BYTE   = 1000;
    localparam int          MPB_W            = 10;
    localparam int          DATA_W           = 32;

    // command codes of an input word
    typedef enum logic [0:0] {
        CMD_TICK    = 1'b0,
        CMD_CONSUME = 1'b1
    } t_cmd;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_UPD  = 6'b000100,
        S_CHK  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

endpackage

### hdl/token_bucket_delay_top.sv
// token bucket rate limiter answering send delays with a bit-serial divider
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_cmd, i_byte_count
//  output    out        o_valid / i_ready    o_wait_ms
//  config    in         i_cfg_we             i_cfg_rate_bps
//
// from accept to ready again a tick word passes the multiply and update states,
// a consume word that needs the divider multiply, update, check, divide and
// output, one at rate zero multiply, update and output, every other one all but
// divide, each plus any wait for the output register. the delay comes from a
// restoring divider: one quotient bit per cycle, 32 bits, on one subtractor.
// reset is synchronous and active low; it leaves rate and balance at zero.
// a waiting result sits in the output register, so the next word is taken
// while it waits; only a second result stalls behind it.
module token_bucket_delay_top #(
    parameter int BURST_SECONDS = 2,
    parameter int BALANCE_WIDTH = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tbd_pkg::DATA_W-1:0]  i_cfg_rate_bps,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tbd_pkg::t_cmd               i_cmd,
    input  logic [tbd_pkg::DATA_W-1:0]  i_byte_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tbd_pkg::DATA_W-1:0]  o_wait_ms
);
    import tbd_pkg::*;

    localparam int BW       = BALANCE_WIDTH;
    localparam int CEIL_MUL = BURST_SECONDS * int'(TICKS_PER_SECOND);
    localparam int CM_W     = $clog2(CEIL_MUL + 1);
    localparam int PW       = DATA_W + CM_W;
    localparam int W2       = (PW > BW) ? PW : BW;
    localparam int SUB_W    = DATA_W + MPB_W;
    localparam int CNT_W    = $clog2(DATA_W);

    // registers
    t_state                 r_state, n_state;
    logic [DATA_W-1:0]      r_rate;
    logic [BW-1:0]          r_ceil;
    logic signed [BW-1:0]   r_bal, n_bal;
    t_cmd                   r_cmd;
    logic [DATA_W-1:0]      r_bytes;
    logic [SUB_W-1:0]       r_sub;
    logic [DATA_W-1:0]      r_rem, n_rem;
    logic [DATA_W-1:0]      r_quo, n_quo;
    logic                   r_divd, n_divd;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    logic [DATA_W-1:0]      r_delay, n_delay;

    // burst ceiling for a newly written rate, clamped to the top balance
    logic [PW-1:0]          ceil_prod;
    logic [W2-1:0]          ceil_ext;
    logic [W2-1:0]          top_ext;
    logic [BW-1:0]          ceil_new;

    assign ceil_prod = PW'(i_cfg_rate_bps) * PW'(CEIL_MUL);
    assign ceil_ext  = W2'(ceil_prod);
    assign top_ext   = W2'({1'b0, {(BW-1){1'b1}}});
    assign ceil_new  = (ceil_ext > top_ext) ? top_ext[BW-1:0] : ceil_ext[BW-1:0];

    // shared arithmetic: balance update and divider step
    logic signed [BW:0]     bal_ext;
    logic signed [BW:0]     tick_sum;
    logic signed [BW:0]     cons_dif;
    logic [BW-1:0]          deficit;
    logic [DATA_W:0]        hi_ext;
    logic [DATA_W:0]        trial;
    logic [DATA_W-1:0]      delay_fin;

    assign bal_ext   = {r_bal[BW-1], r_bal};
    assign tick_sum  = bal_ext + $signed({1'b0, (BW)'(r_rate)});
    assign cons_dif  = bal_ext - $signed({1'b0, (BW)'(r_sub)});
    assign deficit   = BW'(0) - r_bal;
    assign hi_ext    = (DATA_W+1)'(deficit[BW-1:DATA_W]);
    assign trial     = {r_rem, r_quo[DATA_W-1]} - {1'b0, r_rate};
    assign delay_fin = (r_divd && r_quo == '0) ? DATA_W'(1) : r_quo;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_bal       = r_bal;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_divd      = r_divd;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_delay     = r_delay;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_quo  = '0;
                n_divd = 1'b0;
                if (r_cmd == CMD_TICK) begin
                    if (r_rate != '0) begin
                        if (tick_sum >= $signed({1'b0, r_ceil})) begin
                            n_bal = r_ceil;
                        end else begin
                            n_bal = tick_sum[BW-1:0];
                        end
                    end
                    n_state = S_IDLE;
                end else if (r_rate == '0) begin
                    n_state = S_OUT;
                end else begin
                    // underflow past the floor saturates
                    if (cons_dif[BW] != cons_dif[BW-1]) begin
                        n_bal = {1'b1, {(BW-1){1'b0}}};
                    end else begin
                        n_bal = cons_dif[BW-1:0];
                    end
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (!r_bal[BW-1]) begin
                    n_state = S_OUT;
                end else if (hi_ext >= {1'b0, r_rate}) begin
                    // quotient would not fit in 32 bits
                    n_quo   = '1;
                    n_state = S_OUT;
                end else begin
                    n_rem   = DATA_W'(deficit[BW-1:DATA_W]);
                    n_quo   = deficit[DATA_W-1:0];
                    n_divd  = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!trial[DATA_W]) begin
                    n_rem = trial[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
                    n_quo = {r_quo[DATA_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == '1) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_delay     = delay_fin;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // rate write refills the bucket; the user must write it only while idle, the block does not enforce it
        if (i_cfg_we) begin
            n_bal = ceil_new;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= '0;
            r_ceil      <= '0;
            r_bal       <= '0;
            r_out_valid <= 1'b0;
            r_divd      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_bal       <= n_bal;
            r_out_valid <= n_out_valid;
            r_divd      <= n_divd;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                r_rate <= i_cfg_rate_bps;
                r_ceil <= ceil_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd   <= i_cmd;
            r_bytes <= i_byte_count;
        end
        if (r_state == S_MUL) begin
            r_sub <= SUB_W'(r_bytes) * SUB_W'(MILLI_PER_BYTE);
        end
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_delay <= n_delay;
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_wait_ms = r_delay;

    // partial remainder stays below the divisor while dividing
    a_rem_below_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_rate))
        else $error("divider remainder not below rate");

    // balance never exceeds the burst ceiling
    a_bal_le_ceil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_bal[BW-1]) |-> (r_bal <= r_ceil))
        else $error("balance above burst ceiling");

    // an accepted word starts the sequencer
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_MUL))
        else $error("accepted word did not start processing");

endmodule

### sim/tb_token_bucket_delay_top.sv
// self-checking testbench for the token bucket delay block with a bucket tracker
module tb_token_bucket_delay_top;
    import tbd_pkg::*;

    localparam int BURST_S = 2;
    localparam int BAL_W = 48;
    localparam int RATE_SETTLE = 50;
    localparam int TAIL_CYCLES = 60;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_WORDS = 1250;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam longint LEVEL_FLOOR = -(longint'(1) <<< (BAL_W - 1));
    localparam longint LEVEL_TOP = (longint'(1) <<< (BAL_W - 1)) - 1;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [DATA_W-1:0] i_cfg_rate_bps;
    logic              i_valid;
    logic              o_ready;
    t_cmd              i_cmd;
    logic [DATA_W-1:0] i_byte_count;
    logic              o_valid;
    logic              i_ready;
    logic [DATA_W-1:0] o_wait_ms;

    // tracks rate and bucket level, keeps the delays still owed by the block
    class bucket_checker;
        logic [DATA_W-1:0] rate;
        longint            level;
        logic [DATA_W-1:0] due_delays[$];
        int                errors;

        function new();
            rate = '0;
            level = 0;
            errors = 0;
        endfunction

        // burst ceiling in milli-bytes, clamped to the widest positive level
        function longint ceiling();
            longint full_level;
            full_level = longint'({32'd0, rate}) * BURST_S * TICKS_PER_SECOND;
            if (full_level > LEVEL_TOP) begin
                return LEVEL_TOP;
            end
            return full_level;
        endfunction

        // a rate write refills the bucket
        function void load_rate(logic [DATA_W-1:0] r);
            rate = r;
            level = ceiling();
        endfunction

        function int pending();
            return due_delays.size();
        endfunction

        // accepted input word: update the bucket, queue the delay if one is due
        function void note_word(t_cmd c, logic [DATA_W-1:0] n);
            longint full_level;
            longint rate64;
            longint take;
            longint deficit;
            longint quo;
            rate64 = longint'({32'd0, rate});
            if (c == CMD_TICK) begin
                if (rate != 0) begin
                    full_level = ceiling();
                    if (level >= full_level - rate64) begin
                        level = full_level;
                    end else begin
                        level = level + rate64;
                    end
                end
                return;
            end
            // unlimited rate leaves the bucket alone
            if (rate == 0) begin
                due_delays.push_back('0);
                return;
            end
            take = longint'({32'd0, n}) * longint'(MILLI_PER_BYTE);
            if (level < LEVEL_FLOOR + take) begin
                level = LEVEL_FLOOR;
            end else begin
                level = level - take;
            end
            if (level >= 0) begin
                due_delays.push_back('0);
            end else begin
                deficit = -level;
                quo = deficit / rate64;
                if (quo == 0) begin
                    quo = 1;
                end
                if (quo > longint'({32'd0, ALL_ONES})) begin
                    quo = longint'({32'd0, ALL_ONES});
                end
                due_delays.push_back(quo[DATA_W-1:0]);
            end
        endfunction

        // accepted output word against the oldest owed delay
        function void check_delay(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (due_delays.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected delay word: got %0d", got);
                end
                return;
            end
            want = due_delays.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("wait_ms mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    bucket_checker tracker = new();
    bit            no_idle = 1'b0;
    int            hold_cycles = 0;
    int            words_sent = 0;
    int unsigned   cycle_cnt = 0;

    token_bucket_delay_top #(
        .BURST_SECONDS (BURST_S),
        .BALANCE_WIDTH (BAL_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_rate_bps (i_cfg_rate_bps),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_byte_count   (i_byte_count),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_wait_ms      (o_wait_ms)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("token_bucket_delay_top test failed");
        $finish;
    end

    // byte counts mostly scaled to what the rate allows per millisecond
    function automatic logic [DATA_W-1:0] pick_bytes(logic [DATA_W-1:0] r);
        longint per_ms;
        longint amount;
        per_ms = longint'({32'd0, r}) / 1000;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_ONES;
            2: return $urandom;
            default: begin
                amount = per_ms * longint'($urandom_range(0, 40)) +
                         longint'($urandom_range(0, 3));
                if (amount > longint'({32'd0, ALL_ONES})) begin
                    return ALL_ONES;
                end
                return amount[DATA_W-1:0];
            end
        endcase
    endfunction

    // offer one input word after a random gap, hold it until taken
    task automatic send_word(input t_cmd c, input logic [DATA_W-1:0] n);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= c;
        i_byte_count <= n;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_word(c, n);
        words_sent++;
    endtask

    task automatic drain_results();
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // rate write only with the block idle; a trailing tick may still be in flight
    task automatic write_rate(input logic [DATA_W-1:0] r);
        i_valid <= 1'b0;
        drain_results();
        repeat (RATE_SETTLE) @(posedge i_clk);
        i_cfg_rate_bps <= r;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.load_rate(r);
    endtask

    // output side: random stalls, one long hold on request
    initial begin
        int stall;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_cycles != 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 14);
            end
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            tracker.check_delay(o_wait_ms);
        end
    end

    // stimulus
    initial begin
        int phase;
        int chunk;
        int len;
        int kind;
        int n_phase;
        int phase_start;
        int random_start;
        logic [DATA_W-1:0] next_rate;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_rate_bps <= '0;
        i_valid <= 1'b0;
        i_cmd <= CMD_TICK;
        i_byte_count <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unlimited rate straight after reset
        send_word(CMD_CONSUME, '0);
        send_word(CMD_CONSUME, ALL_ONES);
        send_word(CMD_TICK, ALL_ONES);
        send_word(CMD_CONSUME, 32'hA5A5_A5A5);

        // slowest rate: tick at full bucket, small deficit, huge deficit
        write_rate(32'd1);
        send_word(CMD_TICK, '0);
        send_word(CMD_CONSUME, '0);
        send_word(CMD_CONSUME, 32'd1);
        send_word(CMD_CONSUME, 32'd1);
        send_word(CMD_CONSUME, 32'd1);
        send_word(CMD_TICK, 32'h5A5A_5A5A);
        send_word(CMD_CONSUME, ALL_ONES);

        // fastest rate: empty the bucket exactly, then a deficit below one ms
        write_rate(ALL_ONES);
        send_word(CMD_TICK, '0);
        send_word(CMD_CONSUME, ALL_ONES);
        send_word(CMD_CONSUME, ALL_ONES);
        send_word(CMD_CONSUME, 32'd1);
        send_word(CMD_TICK, '0);
        send_word(CMD_CONSUME, '0);

        // ordinary rate around the zero crossing
        write_rate(32'd1000);
        send_word(CMD_CONSUME, 32'd2000);
        send_word(CMD_CONSUME, 32'd1);
        send_word(CMD_CONSUME, 32'h8000_0000);

        // random phases, each at its own rate
        random_start = words_sent;
        phase = 0;
        while (words_sent - random_start < RANDOM_WORDS) begin
            case ($urandom_range(0, 5))
                0: next_rate = '0;
                1: next_rate = $urandom_range(1, 50);
                2: next_rate = $urandom_range(1000, 2000000);
                3: next_rate = $urandom;
                4: next_rate = ALL_ONES;
                default: next_rate = $urandom_range(50, 5000);
            endcase
            if (phase == 0) begin
                next_rate = $urandom_range(1, 8);
            end
            write_rate(next_rate);
            // receiver goes quiet while the sender keeps offering
            if (phase == 1) begin
                hold_cycles = LONG_HOLD;
            end
            n_phase = $urandom_range(60, 140);
            phase_start = words_sent;
            chunk = 0;
            while (words_sent - phase_start < n_phase) begin
                no_idle = ($urandom_range(0, 4) == 0);
                kind = (phase == 0 && chunk == 0) ? 7 : $urandom_range(0, 9);
                case (kind)
                    0, 1, 2, 3, 4: begin
                        // steady traffic, ticks between requests
                        len = $urandom_range(4, 12);
                        repeat (len) begin
                            if ($urandom_range(0, 1) == 0) begin
                                send_word(CMD_TICK, $urandom);
                            end else begin
                                send_word(CMD_CONSUME, pick_bytes(tracker.rate));
                            end
                        end
                    end
                    5, 6: begin
                        // back-to-back requests with no refill
                        len = $urandom_range(3, 10);
                        repeat (len) send_word(CMD_CONSUME, pick_bytes(tracker.rate));
                    end
                    7: begin
                        // drive the balance down onto its negative floor
                        repeat (40) send_word(CMD_CONSUME, ALL_ONES);
                        send_word(CMD_TICK, '0);
                        send_word(CMD_CONSUME, '0);
                    end
                    default: begin
                        len = $urandom_range(3, 8);
                        repeat (len) send_word(t_cmd'($urandom_range(0, 1)), $urandom);
                    end
                endcase
                // sender pauses until every owed delay is back
                if (phase == 2 && chunk == 3) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    drain_results();
                end
                chunk++;
            end
            phase++;
        end

        i_valid <= 1'b0;
        no_idle = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("token_bucket_delay_top test passed");
        end else begin
            $display("token_bucket_delay_top test failed");
        end
        $finish;
    end

endmodule
